@@ hdl/bdeq_pkg.sv @@
// Shared types and codes for the bounded double-ended queue.
package bdeq_pkg;

  // Queue geometry
  localparam int CAPACITY   = 16;
  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Command codes carried by an input item
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  // Per-cell update modes
  localparam logic [1:0] MODE_HOLD       = 2'd0;
  localparam logic [1:0] MODE_FROM_LEFT  = 2'd1;
  localparam logic [1:0] MODE_FROM_RIGHT = 2'd2;
  localparam logic [1:0] MODE_LOAD       = 2'd3;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [1:0]           command;
    logic [WORD_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [WORD_BITS-1:0]  popped_value;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
    logic [WORD_BITS-1:0]  front_value;
    logic [WORD_BITS-1:0]  back_value;
  } out_item_t;

endpackage

@@ hdl/bdeq_cell.sv @@
// One storage cell of the queue chain: holds a word, takes a neighbour's or a new one.
module bdeq_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic [1:0]           mode,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic [WORD_BITS-1:0] load_word,
  output logic [WORD_BITS-1:0] cell_word
);
  import bdeq_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  // Pick the next word by mode
  always_comb begin
    unique case (mode)
      MODE_HOLD:       word_nxt = word_r;
      MODE_FROM_LEFT:  word_nxt = left_word;
      MODE_FROM_RIGHT: word_nxt = right_word;
      MODE_LOAD:       word_nxt = load_word;
    endcase
  end

  // Payload only: no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign cell_word = word_r;

endmodule

@@ hdl/bounded_double_ended_queue_unit.sv @@
// Top level of the bounded double-ended queue built as a chain of shifting cells.
//
// The queue keeps its words in a row of CAPACITY cells with the front word always in
// the first cell and a count of words held. A push at the front shifts the whole row
// one cell towards the back, a pop at the front shifts it one cell towards the front,
// a push at the back loads only the cell picked by the count, a pop at the back changes
// no cell and only lowers the count. Each input item gives exactly one result item. An
// item updates the cells in the cycle it is accepted; the result is formed from the
// updated cells and held in an output register once that register can take it. It is
// formed separately because the back word is read from the cell chain through the
// single count-addressed read mux. A new item is taken while an earlier result still
// waits in the output register; intake stops once an item is accepted until its result
// moves into that register, and during reset. Pushes into a full queue and pops from an
// empty one return status error and leave the queue as it was. No clearing pass runs
// after reset: only cells below the count are ever read.
module bounded_double_ended_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdeq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bdeq_pkg::out_item_t out_item
);
  import bdeq_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam int IW = $clog2(CAPACITY);

  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  logic [1:0]           cell_mode [CAPACITY];
  logic [WORD_BITS-1:0] push_word;

  logic [CW-1:0]        count_r, count_nxt;
  logic                 busy_r;
  logic                 out_valid_r;
  logic                 pend_status_r, pend_status_nxt;
  logic [WORD_BITS-1:0] pend_popped_r, pend_popped_nxt;
  out_item_t            out_r;

  logic          accept;
  logic          advance;
  logic          full;
  logic          empty;
  logic [IW-1:0] back_idx;
  logic [WORD_BITS-1:0] back_word;

  assign push_word = in_item.value;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign back_idx  = IW'(count_r - CW'(1));
  assign back_word = cell_q[back_idx];

  assign in_ready  = rst_n && !busy_r;
  assign accept    = in_valid && in_ready;
  assign advance   = busy_r && (!out_valid_r || out_ready);

  // Decode the item into cell modes, new count and pending result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_mode[i] = MODE_HOLD;
    end
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_popped_nxt = pend_popped_r;
    if (accept) begin
      pend_status_nxt = STATUS_OK;
      pend_popped_nxt = '0;
      unique case (in_item.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            pend_status_nxt = STATUS_ERROR;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              cell_mode[i] = MODE_FROM_LEFT;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            pend_status_nxt = STATUS_ERROR;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (count_r == CW'(i)) cell_mode[i] = MODE_LOAD;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            pend_status_nxt = STATUS_ERROR;
          end else begin
            pend_popped_nxt = cell_q[0];
            for (int i = 0; i < CAPACITY; i++) begin
              cell_mode[i] = MODE_FROM_RIGHT;
            end
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            pend_status_nxt = STATUS_ERROR;
          end else begin
            pend_popped_nxt = back_word;
            count_nxt = count_r - CW'(1);
          end
        end
      endcase
    end
  end

  // Chain of cells: front in cell 0, new front word enters from the left
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = push_word;
    end else begin : g_inner_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_inner_r
      assign right_w = cell_q[g+1];
    end
    bdeq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk        (clk),
      .mode       (cell_mode[g]),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (push_word),
      .cell_word  (cell_q[g])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (advance) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending result and output register
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_popped_r <= pend_popped_nxt;
    if (advance) begin
      out_r.status       <= pend_status_r;
      out_r.popped_value <= pend_popped_r;
      out_r.count        <= count_r;
      out_r.is_empty     <= empty;
      out_r.front_value  <= empty ? '0 : cell_q[0];
      out_r.back_value   <= empty ? '0 : back_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full &&
    (in_item.command == CMD_PUSH_FRONT || in_item.command == CMD_PUSH_BACK)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("successful push did not grow the count");

  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((full && (in_item.command == CMD_PUSH_FRONT ||
                         in_item.command == CMD_PUSH_BACK)) ||
               (empty && (in_item.command == CMD_POP_FRONT ||
                          in_item.command == CMD_POP_BACK)))
    |=> $stable(count_r) && pend_status_r == STATUS_ERROR)
    else $error("rejected item changed the count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_empty |-> out_r.count == '0 &&
    out_r.front_value == '0 && out_r.back_value == '0)
    else $error("empty result carries words");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the bounded double-ended queue unit.
module tb;
  import bdeq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DIR_ROWS     = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 50;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [1:0]  command;
    logic [31:0] value;
    bit          typed;
    out_item_t   result;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // Predicted queue contents, front word at index 0
  logic [31:0] deque_words[$];
  out_item_t   pending_results[$];
  stim_row_t   stim_rows[DIR_ROWS];
  int          row_fill    = 0;
  int          burst_left  = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  rx_mode_t    rx_mode     = RX_OPEN;
  int          rx_left     = 0;

  bounded_double_ended_queue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Advance the predicted queue by one command and form its result
  function automatic out_item_t step_deque(logic [1:0] cmd, logic [31:0] word);
    out_item_t r;
    r = '0;
    r.status = STATUS_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_words.size() >= DEPTH) r.status = STATUS_ERROR;
        else if (cmd == CMD_PUSH_FRONT) deque_words.push_front(word);
        else deque_words.push_back(word);
      end
      default: begin
        if (deque_words.size() == 0) r.status = STATUS_ERROR;
        else if (cmd == CMD_POP_FRONT) r.popped_value = deque_words.pop_front();
        else r.popped_value = deque_words.pop_back();
      end
    endcase
    r.count    = 5'(deque_words.size());
    r.is_empty = (deque_words.size() == 0);
    if (deque_words.size() != 0) begin
      r.front_value = deque_words[0];
      r.back_value  = deque_words[deque_words.size() - 1];
    end
    return r;
  endfunction

  function automatic out_item_t make_result(logic st, logic [31:0] popped, logic [4:0] cnt,
                                            logic empty, logic [31:0] fw, logic [31:0] bw);
    out_item_t r;
    r.status       = st;
    r.popped_value = popped;
    r.count        = cnt;
    r.is_empty     = empty;
    r.front_value  = fw;
    r.back_value   = bw;
    return r;
  endfunction

  task automatic add_row(logic [1:0] cmd, logic [31:0] word, bit typed, out_item_t res);
    stim_rows[row_fill] = '{command: cmd, value: word, typed: typed, result: res};
    row_fill++;
  endtask

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // Offer one item, hold it until taken, then record what it should produce
  task automatic send_item(logic [1:0] cmd, logic [31:0] word, bit typed, out_item_t res);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_item  <= {cmd, word};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_deque(cmd, word);
    pending_results.push_back(typed ? res : predicted);
  endtask

  // Close a burst now and then with a random gap
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall on a pattern picked at random and held for a random stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end else begin
        rx_left = rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ((cycle_count % 5) < 3);
      endcase
    end
  end

  // Compare each result taken with the oldest pending one
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(out_item.status), 32'(want.status));
        check_field("popped_value", out_item.popped_value, want.popped_value);
        check_field("count", 32'(out_item.count), 32'(want.count));
        check_field("is_empty", 32'(out_item.is_empty), 32'(want.is_empty));
        check_field("front_value", out_item.front_value, want.front_value);
        check_field("back_value", out_item.back_value, want.back_value);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    out_item_t   no_result;
    out_item_t   empty_error;
    logic [1:0]  cmd;
    logic [31:0] word;
    int          push_pct;
    int          phase_left;
    no_result   = '0;
    empty_error = make_result(STATUS_ERROR, 32'd0, 5'd0, 1'b1, 32'd0, 32'd0);
    push_pct    = 50;
    phase_left  = 0;

    // Directed rows: errors on empty, extremes, then fill to capacity and push into the full queue
    add_row(CMD_POP_FRONT, 32'h0000_0000, 1'b1, empty_error);
    add_row(CMD_POP_BACK, 32'hFFFF_FFFF, 1'b1, empty_error);
    add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
            make_result(STATUS_OK, 32'd0, 5'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(CMD_PUSH_BACK, 32'h0000_0000, 1'b0, no_result);
    add_row(CMD_POP_BACK, 32'hDEAD_BEEF, 1'b0, no_result);
    add_row(CMD_POP_FRONT, 32'h0000_0000, 1'b1,
            make_result(STATUS_OK, 32'hFFFF_FFFF, 5'd0, 1'b1, 32'd0, 32'd0));
    for (int i = 0; i < DEPTH; i++) begin
      word = {16'(i), 16'hA5C3} ^ ((i % 4 < 2) ? 32'hFFFF_FFFF : 32'h0);
      add_row((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, word, 1'b0, no_result);
    end
    add_row(CMD_PUSH_FRONT, 32'h1234_5678, 1'b0, no_result);
    add_row(CMD_PUSH_BACK, 32'h8765_4321, 1'b0, no_result);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_item(stim_rows[i].command, stim_rows[i].value, stim_rows[i].typed,
                stim_rows[i].result);
      pace_sender();
    end
    drain_results();

    // Random part: phases that lean towards filling, draining or neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      if ($urandom_range(0, 99) < push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      case ($urandom_range(0, 9))
        0:       word = 32'h0000_0000;
        1:       word = 32'hFFFF_FFFF;
        2:       word = 32'h1 << $urandom_range(0, 31);
        default: word = $urandom;
      endcase
      send_item(cmd, word, 1'b0, no_result);
      if (n == RANDOM_ITEMS / 2) drain_results();
      else pace_sender();
    end

    // Let the last results come out, then a short quiet spell
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bdeq_pkg.sv
hdl/bdeq_cell.sv
hdl/bounded_double_ended_queue_unit.sv
sim/tb.sv
